FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the sorted list table engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/slt_pkg.sv
// Types, codes and defaults shared by the sorted list table modules.
package slt_pkg;

   localparam int CAPACITY_DEF    = 32;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FIELD_VALUE_W   = 32;
   localparam int ENTRY_COUNT_W   = 6;

   // opcodes
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_READOUT = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]                      opcode;
      logic signed [FIELD_VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [FIELD_VALUE_W-1:0] out_value;
      logic [1:0]                      status;
      logic                            last;
      logic [ENTRY_COUNT_W-1:0]        entry_count;
   } rsp_word_type;

   // result word handed from the engine to the output register
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } slt_emit_type;

endpackage

FILE: hw/rtl/slt_engine.sv
// Table sequencer: entry memory plus read-modify-write walk for insert and remove, read walk for readout.
`include "assert_macros.svh"

module slt_engine #(
   parameter int CAPACITY    = slt_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  slt_pkg::req_word_type req,
   input  logic                  out_free,
   output logic                  idle,
   output slt_pkg::slt_emit_type emit
);
   import slt_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_INS       = 7'b0000010,
      ST_PUT       = 7'b0000100,
      ST_REM_SCAN  = 7'b0001000,
      ST_REM_SHIFT = 7'b0010000,
      ST_RD        = 7'b0100000,
      ST_RESP      = 7'b1000000
   } state_type;

   logic signed [VALUE_WIDTH-1:0] sorted_entries_mem [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [1:0]                    status_ff, status_in;

   logic                          rd_en, wr_en;
   logic [IDX_W-1:0]              rd_addr, wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic                          is_last;
   logic [IDX_W-1:0]              next_idx, prev_idx;

   assign is_last  = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));
   assign next_idx = idx_ff + IDX_W'(1);
   assign prev_idx = idx_ff - IDX_W'(1);
   assign idle     = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      key_in    = key_ff;
      status_in = status_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data_ff;
      emit      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in    = VALUE_WIDTH'(req.value);
               status_in = STATUS_OK;
               unique case (req.opcode)
                  OP_INSERT: begin
                     if (count_ff == CNT_MAX) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_RESP;
                     end else if (count_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = VALUE_WIDTH'(req.value);
                        count_in = count_ff + CNT_W'(1);
                        state_in = ST_RESP;
                     end else begin
                        // walk down from the top entry
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                        idx_in   = IDX_W'(count_ff - CNT_W'(1));
                        state_in = ST_INS;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_NOT_FOUND;
                        state_in  = ST_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = ST_REM_SCAN;
                     end
                  end
                  OP_READOUT: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = ST_RD;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_INS: begin
            // entries >= key move up one slot; key lands above first smaller one
            wr_en   = 1'b1;
            wr_addr = next_idx;
            if (rd_data_ff < key_ff) begin
               wr_data  = key_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_RESP;
            end else if (idx_ff == '0) begin
               state_in = ST_PUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = prev_idx;
               idx_in  = prev_idx;
            end
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = key_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_RESP;
         end
         ST_REM_SCAN: begin
            priority if (rd_data_ff == key_ff) begin
               if (is_last) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_RESP;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = next_idx;
                  idx_in   = next_idx;
                  state_in = ST_REM_SHIFT;
               end
            end else if (rd_data_ff < key_ff && !is_last) begin
               rd_en   = 1'b1;
               rd_addr = next_idx;
               idx_in  = next_idx;
            end else begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_RESP;
            end
         end
         ST_REM_SHIFT: begin
            // close the gap: entry idx moves down one slot
            wr_en   = 1'b1;
            wr_addr = prev_idx;
            if (is_last) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = next_idx;
               idx_in  = next_idx;
            end
         end
         ST_RD: begin
            // read data holds until the next read, so a stall just waits here
            if (out_free) begin
               emit.valid            = 1'b1;
               emit.word.out_value   = FIELD_VALUE_W'(rd_data_ff);
               emit.word.status      = STATUS_OK;
               emit.word.last        = is_last;
               emit.word.entry_count = ENTRY_COUNT_W'(count_ff);
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = next_idx;
                  idx_in  = next_idx;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               emit.valid            = 1'b1;
               emit.word.out_value   = '0;
               emit.word.status      = status_ff;
               emit.word.last        = 1'b1;
               emit.word.entry_count = ENTRY_COUNT_W'(count_ff);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sorted_entries_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= sorted_entries_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      key_ff    <= key_in;
      status_ff <= status_in;
   end

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_MAX)
   `ASSERT_IMPLIES(a_emit_has_room, clock, reset, emit.valid, out_free)
   `ASSERT_IMPLIES(a_no_rw_overlap, clock, reset, rd_en && wr_en, rd_addr != wr_addr)
   `ASSERT_NEXT(a_resp_returns_idle, clock, reset, state_ff == ST_RESP && out_free,
                state_ff == ST_IDLE)

endmodule

FILE: hw/rtl/slt_out_buf.sv
// Result output register between the engine and the rsp channel.
module slt_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  slt_pkg::slt_emit_type emit,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output slt_pkg::rsp_word_type rsp_word,
   output logic                  out_free
);
   import slt_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // slot is free when empty or its word leaves this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit.word;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: hw/rtl/sorted_list_table.sv
// Sorted list table: bounded ascending multiset of signed values kept in one entry memory.
// Holds up to CAPACITY signed values of VALUE_WIDTH bits in ascending order, in a
// single-port-read / single-port-write memory with a registered read. The req
// value is taken from its low VALUE_WIDTH bits and read out sign extended. Insert
// (opcode 0) walks down from the top entry, moving each entry that is greater or
// equal up one slot, one entry per cycle, and drops the value in the gap. Remove
// (opcode 1) scans up from entry 0 until a match, then walks the rest of the table
// down one slot; a miss stops the scan at the first greater entry or the top one.
// Readout (opcode 2) returns one word per stored entry, one per cycle while rsp is
// not stalled, after a registered read; an empty table returns one word with the
// empty status. Insert on a full table, remove on an empty table, empty readout and
// the unused opcode go straight from idle to their single result word. The rate is
// set by the one memory read per cycle. One item is worked on at a time: req_stall
// is high from the accept until the last result word is loaded into the rsp output
// register, which holds it under rsp_stall while the next item may already start.
// Every non-readout item returns one word with last set; entry_count is the count
// after the operation, in 6 bits. No clearing pass: the count resets to zero and
// only entries below it are read.
module sorted_list_table #(
   parameter int CAPACITY    = slt_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  slt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output slt_pkg::rsp_word_type rsp_word
);
   import slt_pkg::*;

   logic         engine_idle;
   logic         start;
   logic         out_free;
   slt_emit_type emit;

   // take a new word only when the sequencer is idle
   assign req_stall = !engine_idle;
   assign start     = req_valid && engine_idle;

   slt_engine #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_word),
      .out_free (out_free),
      .idle     (engine_idle),
      .emit     (emit)
   );

   slt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .out_free  (out_free)
   );

endmodule

FILE: dv/tb_sorted_list_table.sv
// Testbench for sorted_list_table: scripted and random insert, remove and readout traffic.
`timescale 1ns / 100ps

module tb_sorted_list_table;
   import slt_pkg::*;

   // opcode 3 has no name in the package; the block answers it with a plain ok word
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int HOLD_CYCLES = 300;                 // long receiver hold-off
   localparam int TAIL_CYCLES = 2 * CAPACITY_DEF + 16; // quiet time after the last word
   localparam int PHASE_ITEMS = 47;
   localparam int N_SCRIPT    = 22;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   sorted_list_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: the ascending contents of the table, plus the
   // result words still owed by the block, oldest first.
   // ------------------------------------------------------------------
   logic signed [31:0] sorted_vals [$];
   rsp_word_type       owed_words [$];

   int mismatch_count = 0;
   int n_items = 0, n_words = 0, n_full = 0, n_miss = 0, n_empty = 0, peak_fill = 0;

   // idling knobs; send side is owned by the stimulus process, recv_stall_pct and
   // hold_arm are written with nonblocking assignments so the receiver sees them cleanly
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_arm       = 1'b0;
   bit hold_done      = 1'b0;
   int hold_left      = 0;

   // Directed script. A row marked typed carries its single expected word
   // (status and count); every other row goes through the predictor.
   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] val;
      bit                 typed;
      logic [1:0]         status;
      logic [5:0]         count;
   } script_row_type;

   script_row_type script_rows [N_SCRIPT] = '{
      '{OP_READOUT, 32'sd0,         1'b1, STATUS_EMPTY,     6'd0}, // readout of empty table
      '{OP_REMOVE,  32'sd5,         1'b1, STATUS_NOT_FOUND, 6'd0}, // remove from empty table
      '{OP_UNUSED,  32'sd0,         1'b1, STATUS_OK,        6'd0},
      '{OP_INSERT,  32'sd0,         1'b1, STATUS_OK,        6'd1},
      '{OP_INSERT,  VAL_MAX,        1'b1, STATUS_OK,        6'd2},
      '{OP_INSERT,  VAL_MIN,        1'b1, STATUS_OK,        6'd3},
      '{OP_INSERT,  -32'sd1,        1'b1, STATUS_OK,        6'd4},
      '{OP_INSERT,  32'sd0,         1'b1, STATUS_OK,        6'd5}, // equal value goes in front
      '{OP_INSERT,  32'sd1,         1'b1, STATUS_OK,        6'd6},
      '{OP_READOUT, 32'sd0,         1'b0, STATUS_OK,        6'd0},
      '{OP_REMOVE,  32'sd0,         1'b1, STATUS_OK,        6'd5}, // one of two equal zeros
      '{OP_REMOVE,  32'sd2,         1'b1, STATUS_NOT_FOUND, 6'd5}, // falls between entries
      '{OP_REMOVE,  VAL_MAX,        1'b1, STATUS_OK,        6'd4}, // tail entry
      '{OP_REMOVE,  VAL_MIN,        1'b1, STATUS_OK,        6'd3}, // head entry
      '{OP_INSERT,  VAL_MIN,        1'b1, STATUS_OK,        6'd4},
      '{OP_INSERT,  VAL_MAX,        1'b1, STATUS_OK,        6'd5},
      '{OP_READOUT, 32'sd0,         1'b0, STATUS_OK,        6'd0},
      '{OP_REMOVE,  32'sh7fff_fffe, 1'b1, STATUS_NOT_FOUND, 6'd5}, // lands on max, no match
      '{OP_UNUSED,  -32'sd1,        1'b1, STATUS_OK,        6'd5},
      '{OP_INSERT,  32'sh5555_5555, 1'b1, STATUS_OK,        6'd6},
      '{OP_INSERT,  32'shAAAA_AAAA, 1'b1, STATUS_OK,        6'd7},
      '{OP_READOUT, 32'sd0,         1'b0, STATUS_OK,        6'd0}
   };

   // ------------------------------------------------------------------
   // Predictor: applies one request word to sorted_vals and returns the
   // result words it should cause.
   // ------------------------------------------------------------------
   task automatic table_step(input req_word_type w, ref rsp_word_type words [$]);
      logic signed [31:0] v;
      int                 pos;
      rsp_word_type       r;
      v     = w.value;  // VALUE_WIDTH equals the field width: no narrowing
      words = {};
      pos   = 0;
      while (pos < sorted_vals.size() && sorted_vals[pos] < v) pos++;
      r      = '0;
      r.last = 1'b1;
      unique case (w.opcode)
         OP_INSERT: begin
            if (sorted_vals.size() >= CAPACITY_DEF) begin
               r.status = STATUS_FULL;
               n_full++;
            end else begin
               sorted_vals.insert(pos, v);
               r.status = STATUS_OK;
            end
         end
         OP_REMOVE: begin
            if (pos < sorted_vals.size() && sorted_vals[pos] == v) begin
               sorted_vals.delete(pos);
               r.status = STATUS_OK;
            end else begin
               r.status = STATUS_NOT_FOUND;
               n_miss++;
            end
         end
         OP_READOUT: begin
            if (sorted_vals.size() == 0) begin
               r.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               // one word per entry, last on the final one
               foreach (sorted_vals[k]) begin
                  r.out_value   = sorted_vals[k];
                  r.status      = STATUS_OK;
                  r.last        = (k == sorted_vals.size() - 1);
                  r.entry_count = 6'(sorted_vals.size());
                  words.push_back(r);
               end
               return;
            end
         end
         default: r.status = STATUS_OK;
      endcase
      r.entry_count = 6'(sorted_vals.size());
      words.push_back(r);
      if (sorted_vals.size() > peak_fill) peak_fill = sorted_vals.size();
   endtask

   // one line per mismatch, capped so a broken block cannot flood the log
   task automatic report_mismatch(string what, longint want, longint got);
      if (mismatch_count < 100)
         $display("tb: %t mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic check_word(rsp_word_type got);
      rsp_word_type want;
      n_words++;
      if (owed_words.size() == 0) begin
         report_mismatch("unexpected result word, out_value", 0, got.out_value);
         return;
      end
      want = owed_words.pop_front();
      if (got.out_value !== want.out_value)
         report_mismatch("out_value", want.out_value, got.out_value);
      if (got.status !== want.status)
         report_mismatch("status", want.status, got.status);
      if (got.last !== want.last)
         report_mismatch("last", want.last, got.last);
      if (got.entry_count !== want.entry_count)
         report_mismatch("entry_count", want.entry_count, got.entry_count);
   endtask

   // ------------------------------------------------------------------
   // Request side. Called at a rising edge; holds the word until the
   // handshake, books what it should cause, then maybe idles a while.
   // ------------------------------------------------------------------
   task automatic offer_word(req_word_type w, bit typed, logic [1:0] st, logic [5:0] cnt);
      rsp_word_type words [$];
      int           gap;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      n_items++;
      table_step(w, words);
      if (typed)
         owed_words.push_back('{out_value: '0, status: st, last: 1'b1, entry_count: cnt});
      else
         foreach (words[k]) owed_words.push_back(words[k]);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // values: a quarter small (duplicates, near misses), a quarter taken from the
   // table so removes hit, a tenth extremes, the rest full 32-bit random
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 25 && sorted_vals.size() > 0)
         return sorted_vals[$urandom_range(sorted_vals.size() - 1)];
      if (r < 50)
         return 32'(int'($urandom_range(16)) - 8);
      if (r < 60) begin
         unique case ($urandom_range(5))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return VAL_MIN + 32'sd1;
            default: return VAL_MAX - 32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_opcode(int ins_pct, int rem_pct);
      int r;
      r = $urandom_range(99);
      if (r < ins_pct) return OP_INSERT;
      if (r < ins_pct + rem_pct) return OP_REMOVE;
      if (r < 97) return OP_READOUT;
      return OP_UNUSED;
   endfunction

   // ------------------------------------------------------------------
   // Result side: check each accepted word, then pick next cycle's stall.
   // The long hold-off is counted here, once armed by the stimulus.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) check_word(rsp_word);
      if (hold_arm && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus: reset, the directed script, then four random phases.
   //   phase 0: no idling, insert heavy so the table fills and drops;
   //            the receiver's long hold-off lands here
   //   phase 1: sender idle about half the time, mixed traffic
   //   phase 2: receiver stalls about half the time, remove heavy
   //   phase 3: both sides idle now and then, mixed traffic
   // ------------------------------------------------------------------
   int phase_send [4] = '{0, 51, 0, 22};
   int phase_recv [4] = '{0, 0, 51, 22};
   int phase_ins  [4] = '{85, 45, 30, 50};
   int phase_rem  [4] = '{0, 40, 55, 35};

   initial begin
      req_word_type w;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[i]) begin
         w.opcode = script_rows[i].op;
         w.value  = script_rows[i].val;
         offer_word(w, script_rows[i].typed, script_rows[i].status, script_rows[i].count);
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct   = phase_send[p];
         recv_stall_pct <= phase_recv[p];
         if (p == 0) hold_arm <= 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            w.opcode = pick_opcode(phase_ins[p], phase_rem[p]);
            w.value  = pick_value();
            offer_word(w, 1'b0, STATUS_OK, 6'd0);
         end
      end
      req_valid <= 1'b0;

      // drain, then leave time for any stray word to show up
      while (owed_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d requests, %0d result words checked, table peaked at %0d of %0d",
               n_items, n_words, peak_fill, CAPACITY_DEF);
      $display("tb: %0d dropped on full, %0d remove misses, %0d empty readouts, %0d-cycle hold",
               n_full, n_miss, n_empty, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/slt_pkg.sv
hw/rtl/slt_engine.sv
hw/rtl/slt_out_buf.sv
hw/rtl/sorted_list_table.sv
dv/tb_sorted_list_table.sv
